>>> design/linear_tied_recurrent_cell_core_defines.svh
// assertion macros for the recurrent cell core
// used by the top level; no other dependencies
`ifndef LINEAR_TIED_RECURRENT_CELL_CORE_DEFINES_SVH
`define LINEAR_TIED_RECURRENT_CELL_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define LTRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltrc assertion failed");
// next-cycle implication
`define LTRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltrc assertion failed");
`else
`define LTRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LTRC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/ltrc_pkg.sv
// shared constants, types and the sigmoid table of the recurrent cell core
// no dependencies
`timescale 1ns / 1ps
package ltrc_pkg;

    localparam int DIM        = 64;
    localparam int DATA_W     = 16;
    localparam int IDX_W      = $clog2(DIM);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ACT_W      = 7;
    localparam int OP_W       = 2;
    localparam int WADDR_W    = 2 * IDX_W;
    localparam int ACC_W      = 40;
    localparam int SUM_W      = DATA_W + 1;
    localparam int MUL_A_W    = 2 * DATA_W;
    localparam int PROD_W     = MUL_A_W + SUM_W;
    localparam int MAC_W      = PROD_W + 1;
    localparam int TOT_W      = ACC_W + 2;
    localparam int FRAC_W     = 8;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam int SIG_W      = 16;
    localparam int SIG_N      = 256;
    localparam int SIG_IDX_W  = $clog2(SIG_N);
    localparam int SIG_SHIFT  = 4;
    localparam int SIG_CLAMP  = 2048;
    localparam int GATE_SHIFT = 24;
    localparam int GQ_W       = PROD_W - GATE_SHIFT;

    localparam longint DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam longint DATA_MIN = -DATA_MAX - 64'sd1;
    localparam longint ACC_MAX  = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_MIN  = -ACC_MAX - 64'sd1;
    localparam longint EXP_STEP = 64'sd4162825044;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_BIAS   = 2'd1,
        OP_FEED        = 2'd2,
        OP_LOAD_HIDDEN = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MUL_MAC    = 2'd0,
        MUL_SQUARE = 2'd1,
        MUL_GATE   = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] hidden;
        logic signed [DATA_W-1:0] gated;
        logic                     last;
    } t_result;

    typedef logic [SIG_N-1:0][SIG_W-1:0] t_sig_tab;

    // e^(-m/32) by repeated rounded Q0.32 products, then 2^48/(2^32+e) by
    // shift-subtract; mirrored entries take 1 - s
    function automatic t_sig_tab build_sig_tab();
        t_sig_tab    tab;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] neg;
        tab = '0;
        p   = 64'd1 << 32;
        for (int m = 1; m < SIG_N; m++) begin
            p = (p * 64'(EXP_STEP) + (64'd1 << 31)) >> 32;
            if ((m & 1) != 0) begin
                den = (64'd1 << 32) + p;
                num = (64'd1 << 48) + (den >> 1);
                rem = '0;
                quo = '0;
                for (int b = 63; b >= 0; b--) begin
                    rem = {rem[62:0], num[b]};
                    if (rem >= den) begin
                        rem    = rem - den;
                        quo[b] = 1'b1;
                    end
                end
                neg = (64'd1 << SIG_W) - quo;
                tab[(m + SIG_N - 1) >> 1] = quo[SIG_W-1:0];
                tab[(SIG_N - 1 - m) >> 1] = neg[SIG_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

endpackage

>>> design/linear_tied_recurrent_cell_core.sv
// recurrent cell core: loads are taken while idle; a feed holds the input stalled
// while it runs one multiply-accumulate per row on the shared multiplier
// the feed that closes a step then emits one result per row (two passes through the
// multiplier per row), held up further while the result channel stalls
// synchronous active-low reset clears control, hidden and accumulator valid bits;
// weight and bias memories are not cleared
`timescale 1ns / 1ps
`include "linear_tied_recurrent_cell_core_defines.svh"
module linear_tied_recurrent_cell_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ltrc_pkg::ACT_W-1:0]         i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ltrc_pkg::OP_W-1:0]          i_operation,
    input  logic [ltrc_pkg::IDX_W-1:0]         i_row_index,
    input  logic [ltrc_pkg::IDX_W-1:0]         i_column_index,
    input  logic signed [ltrc_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ltrc_pkg::IDX_W-1:0]         o_element_index,
    output logic signed [ltrc_pkg::DATA_W-1:0] o_hidden_value,
    output logic signed [ltrc_pkg::DATA_W-1:0] o_gated_value,
    output logic                               o_last_of_step
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SUM      = 9'b000000010,
        ST_MAC      = 9'b000000100,
        ST_EMIT_RD  = 9'b000001000,
        ST_EMIT_H   = 9'b000010000,
        ST_SQUARE   = 9'b000100000,
        ST_LATCH_SQ = 9'b001000000,
        ST_GATE     = 9'b010000000,
        ST_PUSH     = 9'b100000000
    } t_state;

    localparam int DW = ltrc_pkg::DATA_W;
    localparam int IW = ltrc_pkg::IDX_W;
    localparam int CW = ltrc_pkg::CNT_W;

    // control
    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            r_v1;
    logic            n_v1;
    logic            r_v2;
    logic [ltrc_pkg::ACT_W-1:0] r_active;
    logic [CW-1:0]   w_n;

    // stores
    logic signed [DW-1:0]             r_weight_mem [ltrc_pkg::DIM*ltrc_pkg::DIM];
    logic signed [DW-1:0]             r_bias_mem   [ltrc_pkg::DIM];
    logic signed [DW-1:0]             r_hidden_mem [ltrc_pkg::DIM];
    logic signed [ltrc_pkg::ACC_W-1:0] r_acc_mem   [ltrc_pkg::DIM];
    logic [ltrc_pkg::DIM-1:0]         r_hid_vld;
    logic [ltrc_pkg::DIM-1:0]         r_acc_vld;

    logic signed [DW-1:0]             r_wt_q;
    logic signed [DW-1:0]             r_bias_q;
    logic signed [DW-1:0]             r_hid_q;
    logic                             r_hidv_q;
    logic signed [ltrc_pkg::ACC_W-1:0] r_acc_q;
    logic                             r_accv_q;

    // datapath registers
    logic [IW-1:0]                    r_row;
    logic signed [DW-1:0]             r_val;
    logic signed [ltrc_pkg::SUM_W-1:0] r_sum;
    logic [IW-1:0]                    r_idx1;
    logic [IW-1:0]                    r_idx2;
    logic signed [ltrc_pkg::ACC_W-1:0] r_acc2;
    logic signed [DW-1:0]             r_h;
    logic [ltrc_pkg::SIG_W-1:0]       r_sig;
    logic [ltrc_pkg::MUL_A_W-1:0]     r_sq;

    // combinational
    ltrc_pkg::t_op                    w_op;
    logic                             w_accept;
    logic                             w_row_ok;
    logic                             w_col_ok;
    logic                             w_wt_we;
    logic                             w_bias_we;
    logic                             w_hid_we;
    logic [IW-1:0]                    w_hid_waddr;
    logic signed [DW-1:0]             w_hid_wdata;
    logic [IW-1:0]                    w_rd_row;
    logic [ltrc_pkg::WADDR_W-1:0]     w_wt_raddr;
    logic signed [DW-1:0]             w_hid_eff;
    logic signed [ltrc_pkg::ACC_W-1:0] w_acc_eff;
    logic signed [ltrc_pkg::PROD_W-1:0] w_prod;
    logic signed [ltrc_pkg::MAC_W-1:0] w_mac;
    logic signed [ltrc_pkg::ACC_W-1:0] w_acc_sat;
    logic signed [ltrc_pkg::TOT_W-1:0] w_tot;
    logic signed [ltrc_pkg::TOT_W-1:0] w_hsh;
    logic signed [DW-1:0]             w_hsat;
    logic signed [DW-1:0]             w_hc;
    logic signed [DW-1:0]             w_hoff;
    logic [ltrc_pkg::SIG_IDX_W-1:0]   w_sig_idx;
    logic [ltrc_pkg::PROD_W-1:0]      w_gsum;
    logic [ltrc_pkg::GQ_W-1:0]        w_gq;
    logic signed [DW-1:0]             w_gated;
    logic                             w_last;
    logic                             w_push;
    logic                             w_can_push;
    ltrc_pkg::t_mul_sel               w_mul_sel;
    ltrc_pkg::t_result                w_res;
    ltrc_pkg::t_result                w_out_res;

    // ---------------------------------------------------------------- control

    assign w_op       = ltrc_pkg::t_op'(i_operation);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_active == '0) begin
            w_n = CW'(1);
        end else if (r_active > ltrc_pkg::ACT_W'(ltrc_pkg::DIM)) begin
            w_n = CW'(ltrc_pkg::DIM);
        end else begin
            w_n = CW'(r_active);
        end
    end

    assign w_last = (r_cnt == (w_n - CW'(1)));
    assign w_push = (r_state == ST_PUSH) && w_can_push;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_v1    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == ltrc_pkg::OP_FEED) && ({1'b0, i_row_index} < w_n)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_MAC;
                n_cnt   = '0;
            end
            ST_MAC: begin
                if (r_cnt < w_n) begin
                    n_v1  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else if (!r_v1 && !r_v2) begin
                    // last position of the step closes it
                    n_cnt   = '0;
                    n_state = ({1'b0, r_row} == (w_n - CW'(1))) ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD:  n_state = ST_EMIT_H;
            ST_EMIT_H:   n_state = ST_SQUARE;
            ST_SQUARE:   n_state = ST_LATCH_SQ;
            ST_LATCH_SQ: n_state = ST_GATE;
            ST_GATE:     n_state = ST_PUSH;
            ST_PUSH: begin
                if (w_can_push) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_state = ST_EMIT_RD;
                        n_cnt   = r_cnt + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_active <= ltrc_pkg::ACT_W'(ltrc_pkg::DIM);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
            if (i_cfg_wr_en) begin
                r_active <= i_cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------- stores

    assign w_row_ok  = ({1'b0, i_row_index} < CW'(ltrc_pkg::DIM));
    assign w_col_ok  = ({1'b0, i_column_index} < CW'(ltrc_pkg::DIM));
    assign w_wt_we   = w_accept && (w_op == ltrc_pkg::OP_LOAD_WEIGHT) && w_row_ok && w_col_ok;
    assign w_bias_we = w_accept && (w_op == ltrc_pkg::OP_LOAD_BIAS) && w_row_ok;

    // hidden store takes loads from the port and write-back during emission
    always_comb begin
        if (r_state == ST_SQUARE) begin
            w_hid_we    = 1'b1;
            w_hid_waddr = r_cnt[IW-1:0];
            w_hid_wdata = r_h;
        end else begin
            w_hid_we    = w_accept && (w_op == ltrc_pkg::OP_LOAD_HIDDEN) && w_row_ok;
            w_hid_waddr = i_row_index;
            w_hid_wdata = i_value;
        end
    end

    // row-major weights, DIM is a power of two
    assign w_rd_row   = r_cnt[IW-1:0];
    assign w_wt_raddr = {w_rd_row, r_row};

    always_ff @(posedge i_clk) begin
        if (w_wt_we) begin
            r_weight_mem[{i_row_index, i_column_index}] <= i_value;
        end
        r_wt_q <= r_weight_mem[w_wt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_bias_we) begin
            r_bias_mem[i_row_index] <= i_value;
        end
        r_bias_q <= r_bias_mem[w_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (w_hid_we) begin
            r_hidden_mem[w_hid_waddr] <= w_hid_wdata;
        end
        r_hid_q  <= r_hidden_mem[i_row_index];
        r_hidv_q <= r_hid_vld[i_row_index];
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc_mem[r_idx2] <= w_acc_sat;
        end
        r_acc_q  <= r_acc_mem[w_rd_row];
        r_accv_q <= r_acc_vld[w_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hid_vld <= '0;
            r_acc_vld <= '0;
        end else begin
            if (w_hid_we) begin
                r_hid_vld[w_hid_waddr] <= 1'b1;
            end
            if (r_v2) begin
                r_acc_vld[r_idx2] <= 1'b1;
            end
            // accumulator goes back to zero once its row is reported
            if (r_state == ST_SQUARE) begin
                r_acc_vld[w_rd_row] <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath

    assign w_hid_eff = r_hidv_q ? r_hid_q : '0;
    assign w_acc_eff = r_accv_q ? r_acc_q : '0;

    always_comb begin
        case (r_state)
            ST_SQUARE:             w_mul_sel = ltrc_pkg::MUL_SQUARE;
            ST_GATE, ST_PUSH:      w_mul_sel = ltrc_pkg::MUL_GATE;
            default:               w_mul_sel = ltrc_pkg::MUL_MAC;
        endcase
    end

    ltrc_mul u_mul (
        .i_clk  (i_clk),
        .i_sel  (w_mul_sel),
        .i_wt   (r_wt_q),
        .i_sum  (r_sum),
        .i_h    (r_h),
        .i_sq   (r_sq),
        .i_sig  (r_sig),
        .o_prod (w_prod)
    );

    // accumulate with saturation to the accumulator range
    assign w_mac = ltrc_pkg::MAC_W'(r_acc2) + ltrc_pkg::MAC_W'(w_prod);

    always_comb begin
        if (w_mac > ltrc_pkg::MAC_W'(ltrc_pkg::ACC_MAX)) begin
            w_acc_sat = ltrc_pkg::ACC_W'(ltrc_pkg::ACC_MAX);
        end else if (w_mac < ltrc_pkg::MAC_W'(ltrc_pkg::ACC_MIN)) begin
            w_acc_sat = ltrc_pkg::ACC_W'(ltrc_pkg::ACC_MIN);
        end else begin
            w_acc_sat = w_mac[ltrc_pkg::ACC_W-1:0];
        end
    end

    // bias, round half up to Q8.8, saturate
    assign w_tot = ltrc_pkg::TOT_W'(w_acc_eff)
                 + (ltrc_pkg::TOT_W'(r_bias_q) <<< ltrc_pkg::FRAC_W)
                 + ltrc_pkg::TOT_W'(ltrc_pkg::ROUND_HALF);
    assign w_hsh = w_tot >>> ltrc_pkg::FRAC_W;

    always_comb begin
        if (w_hsh > ltrc_pkg::TOT_W'(ltrc_pkg::DATA_MAX)) begin
            w_hsat = DW'(ltrc_pkg::DATA_MAX);
        end else if (w_hsh < ltrc_pkg::TOT_W'(ltrc_pkg::DATA_MIN)) begin
            w_hsat = DW'(ltrc_pkg::DATA_MIN);
        end else begin
            w_hsat = w_hsh[DW-1:0];
        end
    end

    // sigmoid index over h clamped to [-8, 8)
    always_comb begin
        if (r_h < DW'(-ltrc_pkg::SIG_CLAMP)) begin
            w_hc = DW'(-ltrc_pkg::SIG_CLAMP);
        end else if (r_h > DW'(ltrc_pkg::SIG_CLAMP - 1)) begin
            w_hc = DW'(ltrc_pkg::SIG_CLAMP - 1);
        end else begin
            w_hc = r_h;
        end
    end

    assign w_hoff    = w_hc + DW'(ltrc_pkg::SIG_CLAMP);
    assign w_sig_idx = w_hoff[ltrc_pkg::SIG_SHIFT +: ltrc_pkg::SIG_IDX_W];

    assign w_gsum = w_prod + (ltrc_pkg::PROD_W'(1) << (ltrc_pkg::GATE_SHIFT - 1));
    assign w_gq   = w_gsum[ltrc_pkg::PROD_W-1:ltrc_pkg::GATE_SHIFT];
    assign w_gated = (w_gq > ltrc_pkg::GQ_W'(ltrc_pkg::DATA_MAX)) ?
                     DW'(ltrc_pkg::DATA_MAX) : w_gq[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= i_row_index;
            r_val <= i_value;
        end
        if (r_state == ST_SUM) begin
            r_sum <= ltrc_pkg::SUM_W'(r_val) + ltrc_pkg::SUM_W'(w_hid_eff);
        end
        r_idx1 <= w_rd_row;
        r_idx2 <= r_idx1;
        r_acc2 <= w_acc_eff;
        if (r_state == ST_EMIT_H) begin
            r_h <= w_hsat;
        end
        if (r_state == ST_SQUARE) begin
            r_sig <= ltrc_pkg::SIG_TAB[w_sig_idx];
        end
        if (r_state == ST_LATCH_SQ) begin
            r_sq <= w_prod[ltrc_pkg::MUL_A_W-1:0];
        end
    end

    // ---------------------------------------------------------------- results

    assign w_res.idx    = w_rd_row;
    assign w_res.hidden = r_h;
    assign w_res.gated  = w_gated;
    assign w_res.last   = w_last;

    ltrc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_res      (w_res),
        .o_can_push (w_can_push),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (w_out_res)
    );

    assign o_element_index = w_out_res.idx;
    assign o_hidden_value  = w_out_res.hidden;
    assign o_gated_value   = w_out_res.gated;
    assign o_last_of_step  = w_out_res.last;

    // ---------------------------------------------------------------- checks

    `LTRC_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_push, w_can_push)
    `LTRC_ASSERT_IMP(a_mac_pipe_in_mac, i_clk, i_rst_n, (r_v1 || r_v2), (r_state == ST_MAC))
    `LTRC_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, (w_push && w_res.last), (r_state == ST_IDLE))
    `LTRC_ASSERT_NXT(a_sum_to_mac, i_clk, i_rst_n, (r_state == ST_SUM), ((r_state == ST_MAC) && (r_cnt == '0)))

endmodule

>>> design/ltrc_mul.sv
// shared signed multiplier with operand select and registered product
// depends on ltrc_pkg
`timescale 1ns / 1ps
module ltrc_mul (
    input  logic                                  i_clk,
    input  ltrc_pkg::t_mul_sel                    i_sel,
    input  logic signed [ltrc_pkg::DATA_W-1:0]    i_wt,
    input  logic signed [ltrc_pkg::SUM_W-1:0]     i_sum,
    input  logic signed [ltrc_pkg::DATA_W-1:0]    i_h,
    input  logic [ltrc_pkg::MUL_A_W-1:0]          i_sq,
    input  logic [ltrc_pkg::SIG_W-1:0]            i_sig,
    output logic signed [ltrc_pkg::PROD_W-1:0]    o_prod
);

    logic signed [ltrc_pkg::MUL_A_W-1:0] w_a;
    logic signed [ltrc_pkg::SUM_W-1:0]   w_b;
    logic signed [ltrc_pkg::PROD_W-1:0]  r_prod;

    always_comb begin
        case (i_sel)
            ltrc_pkg::MUL_MAC: begin
                w_a = ltrc_pkg::MUL_A_W'(i_wt);
                w_b = i_sum;
            end
            ltrc_pkg::MUL_SQUARE: begin
                w_a = ltrc_pkg::MUL_A_W'(i_h);
                w_b = ltrc_pkg::SUM_W'(i_h);
            end
            ltrc_pkg::MUL_GATE: begin
                // square is never negative, table entry is unsigned
                w_a = signed'(i_sq);
                w_b = signed'({1'b0, i_sig});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    assign o_prod = r_prod;

endmodule

>>> design/ltrc_out_buf.sv
// one-entry output register between the sequencer and the result channel
// depends on ltrc_pkg
`timescale 1ns / 1ps
module ltrc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ltrc_pkg::t_result i_res,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_stall,
    output ltrc_pkg::t_result o_res
);

    logic              r_full;
    logic              n_full;
    ltrc_pkg::t_result r_res;

    // room when empty or when the held result leaves this cycle
    assign o_can_push = !r_full || !i_stall;
    assign n_full     = i_push || (r_full && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_full;
    assign o_res   = r_res;

endmodule

>>> sim/tb.sv
// self-checking testbench for linear_tied_recurrent_cell_core: a tracker class
// predicts every result row and checks the outputs; plain tasks drive the ports
// depends on ltrc_pkg and linear_tied_recurrent_cell_core
`timescale 1ns / 1ps
module tb;

    localparam int     DIM             = ltrc_pkg::DIM;
    localparam int     DW              = ltrc_pkg::DATA_W;
    localparam int     IW              = ltrc_pkg::IDX_W;
    localparam int     AW              = ltrc_pkg::ACT_W;
    localparam int     OW              = ltrc_pkg::OP_W;
    localparam int     SIG_N           = ltrc_pkg::SIG_N;
    localparam int     HALF_PERIOD     = 10;
    localparam int     HOLD_CYCLES     = 500;
    localparam int     SETTLE_CYCLES   = 80;
    localparam int     WATCHDOG_CYCLES = 3000;
    localparam int     WIDE_LIMIT      = 8;
    localparam longint ACC_TOP         = (64'sd1 <<< (ltrc_pkg::ACC_W - 1)) - 64'sd1;
    localparam longint H_TOP           = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam longint SIG_LIMIT       = 2048;
    localparam bit [63:0] EXP_FACTOR   = 64'd4162825044;

    typedef struct {
        logic [IW-1:0]        idx;
        logic signed [DW-1:0] hidden;
        logic signed [DW-1:0] gated;
        logic                 is_last;
    } t_row_result;

    class cell_tracker;
        logic signed [DW-1:0] weight_mem [0:DIM-1][0:DIM-1];
        logic signed [DW-1:0] bias_mem   [0:DIM-1];
        logic signed [DW-1:0] hidden_mem [0:DIM-1];
        bit                   weight_set [0:DIM-1][0:DIM-1];
        bit                   bias_set   [0:DIM-1];
        longint               acc        [0:DIM-1];
        int unsigned          sig_lut    [0:SIG_N-1];
        logic [AW-1:0]        active_size;
        t_row_result          due_rows[$];
        int unsigned          mismatches;
        int unsigned          rows_seen;
        int unsigned          steps_closed;

        function new();
            bit [63:0] p;
            bit [63:0] den;
            bit [63:0] s;
            foreach (weight_mem[r, c]) begin
                weight_mem[r][c] = '0;
                weight_set[r][c] = 1'b0;
            end
            for (int r = 0; r < DIM; r++) begin
                bias_mem[r]   = '0;
                bias_set[r]   = 1'b0;
                hidden_mem[r] = '0;
                acc[r]        = 0;
            end
            active_size  = 7'd64;
            mismatches   = 0;
            rows_seen    = 0;
            steps_closed = 0;
            // e^(-m/32) by rounded q0.32 products; odd m give the table pairs
            p = 64'd1 << 32;
            for (int m = 1; m < SIG_N; m++) begin
                p = (p * EXP_FACTOR + (64'd1 << 31)) >> 32;
                if (m % 2 == 1) begin
                    den = (64'd1 << 32) + p;
                    s   = ((64'd1 << 48) + den / 2) / den;
                    sig_lut[(m + SIG_N - 1) / 2] = s[31:0];
                    sig_lut[(SIG_N - 1 - m) / 2] = 32'(64'd65536 - s);
                end
            end
        endfunction

        function void set_active(logic [AW-1:0] v);
            active_size = v;
        endfunction

        function int unsigned rows_in_use();
            int unsigned n;
            n = active_size;
            if (n == 0) n = 1;
            if (n > DIM) n = DIM;
            return n;
        endfunction

        function int pending();
            return due_rows.size();
        endfunction

        function void close_step(int unsigned n);
            longint      tot;
            longint      h;
            longint      hc;
            bit [63:0]   sq;
            bit [63:0]   g;
            t_row_result r;
            for (int i = 0; i < n; i++) begin
                tot = acc[i] + longint'(bias_mem[i]) * 256;
                h   = (tot + 128) >>> 8;
                if (h > H_TOP) h = H_TOP;
                else if (h < -H_TOP - 1) h = -H_TOP - 1;
                hc = h < -SIG_LIMIT ? -SIG_LIMIT : (h > SIG_LIMIT - 1 ? SIG_LIMIT - 1 : h);
                sq = h * h;
                g  = (sq * sig_lut[(hc + SIG_LIMIT) >> 4] + (64'd1 << 23)) >> 24;
                if (g > H_TOP) g = H_TOP;
                hidden_mem[i] = h[DW-1:0];
                acc[i]        = 0;
                r.idx     = IW'(i);
                r.hidden  = h[DW-1:0];
                r.gated   = g[DW-1:0];
                r.is_last = (i == n - 1);
                due_rows.push_back(r);
            end
            steps_closed++;
        endfunction

        function void take_input(ltrc_pkg::t_op op, logic [IW-1:0] row, logic [IW-1:0] col,
                                 logic signed [DW-1:0] val);
            int unsigned n;
            longint      sum;
            longint      a;
            n = rows_in_use();
            case (op)
                ltrc_pkg::OP_LOAD_WEIGHT: begin
                    weight_mem[row][col] = val;
                    weight_set[row][col] = 1'b1;
                end
                ltrc_pkg::OP_LOAD_BIAS: begin
                    bias_mem[row] = val;
                    bias_set[row] = 1'b1;
                end
                ltrc_pkg::OP_LOAD_HIDDEN: hidden_mem[row] = val;
                ltrc_pkg::OP_FEED: begin
                    // positions at or beyond the active size are dropped
                    if (row < n) begin
                        sum = longint'(val) + longint'(hidden_mem[row]);
                        for (int i = 0; i < n; i++) begin
                            a = acc[i] + longint'(weight_mem[i][row]) * sum;
                            if (a > ACC_TOP) a = ACC_TOP;
                            else if (a < -ACC_TOP - 1) a = -ACC_TOP - 1;
                            acc[i] = a;
                        end
                        if (row == n - 1) close_step(n);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_row(logic [IW-1:0] idx, logic signed [DW-1:0] hid,
                                  logic signed [DW-1:0] gat, logic is_last);
            t_row_result want;
            rows_seen++;
            if (due_rows.size() == 0) begin
                $display("%0t: result with nothing outstanding: row %0d hidden %0d gated %0d",
                         $time, idx, hid, gat);
                mismatches++;
                return;
            end
            want = due_rows.pop_front();
            if (idx !== want.idx) begin
                $display("%0t: element index expected %0d actual %0d", $time, want.idx, idx);
                mismatches++;
            end
            if (hid !== want.hidden) begin
                $display("%0t: row %0d hidden value expected %0d actual %0d",
                         $time, want.idx, want.hidden, hid);
                mismatches++;
            end
            if (gat !== want.gated) begin
                $display("%0t: row %0d gated value expected %0d actual %0d",
                         $time, want.idx, want.gated, gat);
                mismatches++;
            end
            if (is_last !== want.is_last) begin
                $display("%0t: row %0d last of step expected %0b actual %0b",
                         $time, want.idx, want.is_last, is_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [AW-1:0]        i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OW-1:0]        i_operation;
    logic [IW-1:0]        i_row_index;
    logic [IW-1:0]        i_column_index;
    logic signed [DW-1:0] i_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [IW-1:0]        o_element_index;
    logic signed [DW-1:0] o_hidden_value;
    logic signed [DW-1:0] o_gated_value;
    logic                 o_last_of_step;

    cell_tracker tracker = new();
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          holding = 1'b0;
    int unsigned items_sent = 0;

    linear_tied_recurrent_cell_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_row_index     (i_row_index),
        .i_column_index  (i_column_index),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_element_index (o_element_index),
        .o_hidden_value  (o_hidden_value),
        .o_gated_value   (o_gated_value),
        .o_last_of_step  (o_last_of_step)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one; none while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DW-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'sh7fff;
        if (r < 16) return 16'sh8000;
        if (r < 20) return 16'sh0000;
        if (r < 55) return DW'($urandom);
        return DW'(int'($urandom_range(0, 1023)) - 512);
    endfunction

    // weights kept mostly within +-0.5 so hidden values do not all saturate
    function automatic logic signed [DW-1:0] rand_weight();
        if ($urandom_range(0, 9) == 0) return DW'($urandom);
        return DW'(int'($urandom_range(0, 255)) - 128);
    endfunction

    // wide steps only ever feed their closing position
    function automatic logic [IW-1:0] pick_pos(int unsigned n);
        if (n > WIDE_LIMIT) return IW'(n - 1);
        return IW'($urandom_range(0, n - 1));
    endfunction

    task automatic send_item(ltrc_pkg::t_op op, logic [IW-1:0] row, logic [IW-1:0] col,
                             logic signed [DW-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_row_index    <= row;
        i_column_index <= col;
        i_value        <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_input(op, row, col, val);
        items_sent++;
    endtask

    task automatic send_random_load();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            send_item(ltrc_pkg::OP_LOAD_WEIGHT, IW'($urandom), IW'($urandom), rand_weight());
        else if (r == 1)
            send_item(ltrc_pkg::OP_LOAD_BIAS, IW'($urandom), IW'($urandom), rand_value());
        else
            send_item(ltrc_pkg::OP_LOAD_HIDDEN, IW'($urandom), IW'($urandom), rand_value());
    endtask

    // a feed first loads any weight or bias it would read that is still unwritten
    task automatic send_feed(logic [IW-1:0] pos, logic signed [DW-1:0] val);
        int unsigned n;
        n = tracker.rows_in_use();
        if (pos < n) begin
            for (int i = 0; i < n; i++) begin
                if (!tracker.weight_set[i][pos])
                    send_item(ltrc_pkg::OP_LOAD_WEIGHT, IW'(i), pos, rand_weight());
                if (pos == n - 1 && !tracker.bias_set[i])
                    send_item(ltrc_pkg::OP_LOAD_BIAS, IW'(i), '0, rand_value());
            end
        end
        send_item(ltrc_pkg::OP_FEED, pos, IW'($urandom), val);
    endtask

    task automatic send_whole_step(int unsigned n);
        if (n > WIDE_LIMIT) begin
            send_feed(IW'(n - 1), rand_value());
        end else begin
            // now and then a load slipped in mid-step
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) send_random_load();
                send_feed(IW'(k), rand_value());
            end
        end
    endtask

    // stop offering, wait for every outstanding row, then let the core go quiet
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_active_size(logic [AW-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.set_active(v);
    endtask

    task automatic run_random_phase(int unsigned budget);
        int unsigned   start;
        int            kind;
        int            upto;
        int unsigned   n;
        ltrc_pkg::t_op op;
        logic [IW-1:0] row;
        n     = tracker.rows_in_use();
        start = items_sent;
        send_whole_step(n);
        while (items_sent - start < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                send_whole_step(n);
            end else if (kind < 65) begin
                op  = ltrc_pkg::t_op'($urandom_range(0, 3));
                row = IW'($urandom);
                if (op == ltrc_pkg::OP_FEED) begin
                    if (row < n) row = pick_pos(n);
                    send_feed(row, DW'($urandom));
                end else begin
                    send_item(op, row, IW'($urandom), DW'($urandom));
                end
            end else if (kind < 85 && n > 1 && n <= WIDE_LIMIT) begin
                // partial step with repeated and skipped positions
                upto = $urandom_range(1, n > 4 ? 4 : n);
                for (int j = 0; j < upto; j++)
                    send_feed(IW'($urandom_range(0, n - 2)), rand_value());
            end else begin
                upto = $urandom_range(1, 4);
                for (int j = 0; j < upto; j++)
                    send_random_load();
            end
        end
        // close any open step so the accumulators are clear before reconfiguring
        send_feed(IW'(n - 1), rand_value());
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.compare_row(o_element_index, o_hidden_value, o_gated_value,
                                o_last_of_step);
    end

    // receiver: random stall pattern, plus one long hold-off on request
    initial begin
        int busy_len;
        int free_len;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holding = 1'b0;
            end
            busy_len = pick_gap();
            if (busy_len > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (busy_len - 1) @(negedge i_clk);
            end
            free_len = calm ? 40 : $urandom_range(1, 8);
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat (free_len - 1) @(negedge i_clk);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [AW-1:0] phase_sizes [0:8];
        phase_sizes    = '{7'd1, 7'd0, 7'd5, 7'd127, 7'd3, 7'd8, 7'd2, 7'd7, 7'd64};
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_operation    = ltrc_pkg::OP_LOAD_WEIGHT;
        i_row_index    = '0;
        i_column_index = '0;
        i_value        = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full-width steps at the reset value of the active size, last column only
        send_item(ltrc_pkg::OP_LOAD_WEIGHT, 6'd63, 6'd63, 16'sh8000);
        send_item(ltrc_pkg::OP_LOAD_WEIGHT, 6'd0, 6'd63, 16'sh7fff);
        send_item(ltrc_pkg::OP_LOAD_BIAS, 6'd63, 6'd0, 16'sh7fff);
        send_item(ltrc_pkg::OP_LOAD_BIAS, 6'd0, 6'd63, 16'sh8000);
        send_item(ltrc_pkg::OP_LOAD_HIDDEN, 6'd63, 6'd0, 16'sh8000);
        send_feed(6'd63, 16'sh8000);
        send_item(ltrc_pkg::OP_LOAD_HIDDEN, 6'd63, 6'd0, 16'sh7fff);
        send_item(ltrc_pkg::OP_LOAD_WEIGHT, 6'd2, 6'd63, 16'sh7fff);
        send_feed(6'd63, 16'sh7fff);
        settle_idle();

        write_active_size(7'd4);
        send_feed(6'd40, 16'sh1234);
        send_feed(6'd63, 16'sh7fff);
        send_feed(6'd1, 16'shffff);
        send_feed(6'd2, 16'sh0001);
        send_feed(6'd3, 16'sh5555);
        send_item(ltrc_pkg::OP_LOAD_HIDDEN, 6'd1, 6'd0, 16'sh7f00);
        send_item(ltrc_pkg::OP_LOAD_WEIGHT, 6'd0, 6'd0, 16'sh8000);
        send_item(ltrc_pkg::OP_LOAD_WEIGHT, 6'd1, 6'd0, 16'sh7fff);
        send_feed(6'd0, 16'sh8000);
        send_feed(6'd1, 16'sh7fff);
        send_feed(6'd2, 16'shaaaa);
        send_feed(6'd3, 16'sh0000);

        for (int ph = 0; ph < 9; ph++) begin
            settle_idle();
            write_active_size(phase_sizes[ph]);
            calm = (ph == 1 || ph == 5);
            if (ph == 2) begin
                hold_req = 1'b1;
                wait (holding);
            end
            run_random_phase(tracker.rows_in_use() > WIDE_LIMIT ? 3 : 14);
        end
        settle_idle();

        $display("%0d input transfers, %0d result rows over %0d steps",
                 items_sent, tracker.rows_seen, tracker.steps_closed);
        $display("active sizes 0 to 127, full-scale values, mid-step loads, one long hold-off");
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
